// ----- hdl/smul_pkg.sv -----
`default_nettype none
// Shared types, codes and helper functions of the signed multiply unit.
package smul_pkg;

	// Operation and operand size codes.
	typedef enum logic [1:0] {
		SZ_8  = 2'd0,
		SZ_16 = 2'd1,
		SZ_32 = 2'd2,
		SZ_64 = 2'd3
	} size_t;

	// Instruction forms.
	typedef enum logic {
		REQ_WIDEN = 1'b0,
		REQ_TRUNC = 1'b1
	} req_t;

	localparam int unsigned DATA_W      = 64;
	localparam int unsigned HALF_W      = DATA_W / 2;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified request as it travels from the front to the back.
	typedef struct packed {
		req_t              req_type;
		size_t             op_size;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} cmd_t;

	// Sign-extend the low bits of a value selected by a size code.
	function automatic logic [DATA_W-1:0] sext(input logic [DATA_W-1:0] v, input size_t sz);
		logic [DATA_W-1:0] r;
		case (sz)
			SZ_8:    r = {{56{v[7]}}, v[7:0]};
			SZ_16:   r = {{48{v[15]}}, v[15:0]};
			SZ_32:   r = {{32{v[31]}}, v[31:0]};
			SZ_64:   r = v;
			default: r = v;
		endcase
		return r;
	endfunction

	// Mask of the low bits covered by a size code.
	function automatic logic [DATA_W-1:0] low_mask(input size_t sz);
		logic [DATA_W-1:0] r;
		case (sz)
			SZ_8:    r = {56'd0, 8'hFF};
			SZ_16:   r = {48'd0, 16'hFFFF};
			SZ_32:   r = {32'd0, 32'hFFFF_FFFF};
			SZ_64:   r = {DATA_W{1'b1}};
			default: r = {DATA_W{1'b1}};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/smul_front.sv -----
`default_nettype none
// Front end: accepts requests and sign-extends both operands by instruction form.
module smul_front (
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      req_type,
	input  wire logic [1:0]                op_size,
	input  wire logic [63:0]               operand_a,
	input  wire logic [63:0]               operand_b,
	input  wire logic [1:0]                a_size,
	input  wire logic [1:0]                b_size,
	output logic                           push,
	output smul_pkg::cmd_t                 push_cmd,
	input  wire logic                      q_ready
);
	import smul_pkg::*;

	size_t sz_a;
	size_t sz_b;

	// The truncating form extends each source from its own size; the widening
	// form takes both as signed values of the operation size.
	always_comb begin
		if (req_t'(req_type) == REQ_TRUNC) begin
			sz_a = size_t'(a_size);
			sz_b = size_t'(b_size);
		end else begin
			sz_a = size_t'(op_size);
			sz_b = size_t'(op_size);
		end
		push_cmd.req_type = req_t'(req_type);
		push_cmd.op_size  = size_t'(op_size);
		push_cmd.a        = sext(operand_a, sz_a);
		push_cmd.b        = sext(operand_b, sz_b);
	end

	// A request enters the queue whenever there is room.
	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;

endmodule
`default_nettype wire

// ----- hdl/smul_queue.sv -----
`default_nettype none
// Short request queue between the front end and the multiplier pipeline.
module smul_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire smul_pkg::cmd_t push_cmd,
	output logic                q_ready,
	input  wire logic           pop,
	output logic                q_valid,
	output smul_pkg::cmd_t      head_cmd
);
	import smul_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];
	assign do_push  = push & q_ready;
	assign do_pop   = pop & q_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/smul_back.sv -----
`default_nettype none
// Back end: four-stage signed 64x64 multiplier with flag and result formatting.
module smul_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire smul_pkg::cmd_t head_cmd,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [63:0]         result_low,
	output logic [63:0]         result_high,
	output logic                high_valid,
	output logic                overflow_flag
);
	import smul_pkg::*;

	logic                en;

	// Stage 1: partial products.
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [DATA_W-1:0]   ll_s1;
	logic [DATA_W-1:0]   lh_s1;
	logic [DATA_W-1:0]   hl_s1;
	logic [DATA_W-1:0]   hh_s1;

	// Stage 2: unsigned 128-bit product.
	logic                valid_s2;
	cmd_t                cmd_s2;
	logic [2*DATA_W-1:0] prod_s2;

	// Stage 3: signed product.
	logic                valid_s3;
	req_t                req_s3;
	size_t               size_s3;
	logic [DATA_W-1:0]   lo_s3;
	logic [DATA_W-1:0]   hi_s3;

	// Stage 3 combinational results.
	logic [DATA_W-1:0]   ext_lo;
	logic [DATA_W-1:0]   fill;
	logic [DATA_W-1:0]   mask;
	logic [DATA_W-1:0]   r_low;
	logic [DATA_W-1:0]   r_high;
	logic                r_hv;
	logic                r_ovf;

	// The whole pipeline advances unless a finished result is held.
	assign en  = !out_valid || out_ready;
	assign pop = en && q_valid;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= q_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	// Four 32x32 unsigned partial products of the extended operands.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= head_cmd;
			ll_s1  <= head_cmd.a[HALF_W-1:0] * head_cmd.b[HALF_W-1:0];
			lh_s1  <= head_cmd.a[HALF_W-1:0] * head_cmd.b[DATA_W-1:HALF_W];
			hl_s1  <= head_cmd.a[DATA_W-1:HALF_W] * head_cmd.b[HALF_W-1:0];
			hh_s1  <= head_cmd.a[DATA_W-1:HALF_W] * head_cmd.b[DATA_W-1:HALF_W];
		end
	end

	// Sum of the partial products at their weights.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd_s1;
			prod_s2 <= {{DATA_W{1'b0}}, ll_s1}
				+ {{HALF_W{1'b0}}, lh_s1, {HALF_W{1'b0}}}
				+ {{HALF_W{1'b0}}, hl_s1, {HALF_W{1'b0}}}
				+ {hh_s1, {DATA_W{1'b0}}};
		end
	end

	// Signed correction of the upper half.
	always_ff @(posedge clk) begin
		if (en) begin
			req_s3  <= cmd_s2.req_type;
			size_s3 <= cmd_s2.op_size;
			lo_s3   <= prod_s2[DATA_W-1:0];
			hi_s3   <= prod_s2[2*DATA_W-1:DATA_W]
				- (cmd_s2.a[DATA_W-1] ? cmd_s2.b : {DATA_W{1'b0}})
				- (cmd_s2.b[DATA_W-1] ? cmd_s2.a : {DATA_W{1'b0}});
		end
	end

	// Flag: the product fits when it equals its own sign extension from the size.
	always_comb begin
		ext_lo = sext(lo_s3, size_s3);
		fill   = {DATA_W{ext_lo[DATA_W-1]}};
		r_ovf  = !((lo_s3 == ext_lo) && (hi_s3 == fill));
		mask   = low_mask(size_s3);
		r_low  = lo_s3 & mask;
		r_high = '0;
		r_hv   = 1'b0;
		if (req_s3 == REQ_WIDEN) begin
			r_hv = (size_s3 != SZ_8);
			case (size_s3)
				SZ_8:    r_low  = {48'd0, lo_s3[15:0]};
				SZ_16:   r_high = {48'd0, lo_s3[31:16]};
				SZ_32:   r_high = {32'd0, lo_s3[63:32]};
				SZ_64:   r_high = hi_s3;
				default: r_high = hi_s3;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			result_low    <= r_low;
			result_high   <= r_high;
			high_valid    <= r_hv;
			overflow_flag <= r_ovf;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/signed_multiply_with_overflow_flags_unit.sv -----
`default_nettype none
// Top level of the signed multiply unit with overflow flag.
// Path: a request enters the queue, then stages 1, 2 and 3, then the output register.
// Throughput: one request per cycle unless output stalls; four-stage, fully pipelined multiplier.
// A two-entry queue takes up to two more requests while a result waits at the output.
// Reset clears the queue and all pipeline valid bits; data registers are not reset.
module signed_multiply_with_overflow_flags_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [1:0]  op_size,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire logic [1:0]  a_size,
	input  wire logic [1:0]  b_size,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_low,
	output logic [63:0]      result_high,
	output logic             high_valid,
	output logic             overflow_flag
);
	import smul_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_ready;
	logic q_valid;
	logic pop;
	cmd_t head_cmd;

	// Request classification.
	smul_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.op_size   (op_size),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.a_size    (a_size),
		.b_size    (b_size),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_ready   (q_ready)
	);

	// Decoupling queue.
	smul_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_ready  (q_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.head_cmd (head_cmd)
	);

	// Multiplier pipeline.
	smul_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_low    (result_low),
		.result_high   (result_high),
		.high_valid    (high_valid),
		.overflow_flag (overflow_flag)
	);

	// A full queue is never empty.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("queue reports full while empty");

	// An accepted request is waiting in the queue in the next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> q_valid)
		else $error("accepted request missing from queue");

	// Without a high half to write back, the high result is zero.
	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !high_valid) |-> (result_high == '0))
		else $error("high result nonzero without high_valid");

endmodule
`default_nettype wire
